// ===== src/ppt_pkg.sv =====
package ppt_pkg;

   localparam int Q_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * Q_W;
   localparam int SUM_W = PROD_W + 2;
   localparam int MAG_W = PROD_W;
   localparam int DIV_STEPS = Q_W;
   localparam int DIV_LAT = DIV_STEPS + 2;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic signed [SUM_W-1:0] DEN_ONE = SUM_W'(1) << (2 * FRAC_W);
   localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

   typedef enum logic [2:0] {
      COEF_A,
      COEF_B,
      COEF_C,
      COEF_D,
      COEF_E,
      COEF_F,
      COEF_G,
      COEF_H
   } coef_sel_type;

   localparam logic [Q_W-1:0] COEF_ONE = Q_W'(1) << FRAC_W;

   typedef struct packed {
      logic signed [Q_W-1:0] in_x;
      logic signed [Q_W-1:0] in_y;
   } req_word_type;

   typedef struct packed {
      logic signed [Q_W-1:0] out_x;
      logic signed [Q_W-1:0] out_y;
      logic                  zero_denominator;
      logic                  saturated;
   } rsp_word_type;

   typedef struct packed {
      logic [Q_W-1:0] coef_a;
      logic [Q_W-1:0] coef_b;
      logic [Q_W-1:0] coef_c;
      logic [Q_W-1:0] coef_d;
      logic [Q_W-1:0] coef_e;
      logic [Q_W-1:0] coef_f;
      logic [Q_W-1:0] coef_g;
      logic [Q_W-1:0] coef_h;
   } coef_set_type;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic             neg_x;
      logic             neg_y;
      logic [MAG_W-1:0] num_x;
      logic [MAG_W-1:0] num_y;
      logic [MAG_W-1:0] den;
   } lin_out_type;

endpackage

// ===== src/ppt_linear.sv =====
module ppt_linear (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  ppt_pkg::req_word_type      in_word,
   input  ppt_pkg::coef_set_type      coef,
   output ppt_pkg::lin_out_type       lin_out
);
   import ppt_pkg::*;

   logic                     v_prod_ff;
   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff, prod_d_ff, prod_e_ff, prod_g_ff, prod_h_ff;
   logic signed [Q_W-1:0]    off_x_ff, off_y_ff;

   logic                     v_sum_ff;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_y_ff, sum_d_ff;
   logic signed [SUM_W-1:0]  off_x_ext, off_y_ext;

   logic signed [SUM_W-1:0]  abs_x, abs_y, abs_d;
   lin_out_type              out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_prod_ff <= 1'b0;
         v_sum_ff <= 1'b0;
      end else if (en) begin
         v_prod_ff <= in_valid;
         v_sum_ff <= v_prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a_ff <= $signed(coef.coef_a) * in_word.in_x;
         prod_b_ff <= $signed(coef.coef_b) * in_word.in_y;
         prod_d_ff <= $signed(coef.coef_d) * in_word.in_x;
         prod_e_ff <= $signed(coef.coef_e) * in_word.in_y;
         prod_g_ff <= $signed(coef.coef_g) * in_word.in_x;
         prod_h_ff <= $signed(coef.coef_h) * in_word.in_y;
         off_x_ff <= $signed(coef.coef_c);
         off_y_ff <= $signed(coef.coef_f);
      end
   end

   assign off_x_ext = $signed({{(SUM_W-Q_W-FRAC_W){off_x_ff[Q_W-1]}}, off_x_ff, {FRAC_W{1'b0}}});
   assign off_y_ext = $signed({{(SUM_W-Q_W-FRAC_W){off_y_ff[Q_W-1]}}, off_y_ff, {FRAC_W{1'b0}}});

   always_ff @(posedge clock) begin
      if (en) begin
         sum_x_ff <= SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff) + off_x_ext;
         sum_y_ff <= SUM_W'(prod_d_ff) + SUM_W'(prod_e_ff) + off_y_ext;
         sum_d_ff <= SUM_W'(prod_g_ff) + SUM_W'(prod_h_ff) + DEN_ONE;
      end
   end

   assign abs_x = sum_x_ff[SUM_W-1] ? -sum_x_ff : sum_x_ff;
   assign abs_y = sum_y_ff[SUM_W-1] ? -sum_y_ff : sum_y_ff;
   assign abs_d = sum_d_ff[SUM_W-1] ? -sum_d_ff : sum_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= v_sum_ff;
      end
      if (en) begin
         out_ff.zero <= (sum_d_ff == '0);
         out_ff.neg_x <= sum_x_ff[SUM_W-1] ^ sum_d_ff[SUM_W-1];
         out_ff.neg_y <= sum_y_ff[SUM_W-1] ^ sum_d_ff[SUM_W-1];
         out_ff.num_x <= abs_x[MAG_W-1:0];
         out_ff.num_y <= abs_y[MAG_W-1:0];
         out_ff.den <= abs_d[MAG_W-1:0];
      end
   end

   assign lin_out = out_ff;

endmodule

// ===== src/ppt_divider.sv =====
module ppt_divider (
   input  logic                            clock,
   input  logic                            en,
   input  logic [ppt_pkg::MAG_W-1:0]       num_mag,
   input  logic [ppt_pkg::MAG_W-1:0]       den_mag,
   input  logic                            neg,
   output logic signed [ppt_pkg::Q_W-1:0]  quot,
   output logic                            sat
);
   import ppt_pkg::*;

   logic [MAG_W-1:0] rem_ff [DIV_STEPS+1];
   logic [MAG_W-1:0] den_ff [DIV_STEPS+1];
   logic [Q_W-1:0]   low_ff [DIV_STEPS+1];
   logic [Q_W-1:0]   quo_ff [DIV_STEPS+1];
   logic             neg_ff [DIV_STEPS+1];
   logic             ovf_ff [DIV_STEPS+1];

   logic [MAG_W-1:0] num_hi;
   logic [Q_W-1:0]   res;
   logic             res_sat;
   logic [Q_W-1:0]   quot_ff;
   logic             sat_ff;

   assign num_hi = {{FRAC_W{1'b0}}, num_mag[MAG_W-1:FRAC_W]};

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= (num_hi >= den_mag);
         rem_ff[0] <= num_hi;
         low_ff[0] <= {num_mag[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
         quo_ff[0] <= '0;
         den_ff[0] <= den_mag;
         neg_ff[0] <= neg;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      logic           ge;

      assign trial = {rem_ff[k-1], low_ff[k-1][Q_W-1]};
      assign diff = trial - {1'b0, den_ff[k-1]};
      assign ge = (trial >= {1'b0, den_ff[k-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            quo_ff[k] <= {quo_ff[k-1][Q_W-2:0], ge};
            low_ff[k] <= {low_ff[k-1][Q_W-2:0], 1'b0};
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   always_comb begin
      res = quo_ff[DIV_STEPS];
      res_sat = 1'b0;
      if (ovf_ff[DIV_STEPS]) begin
         res_sat = 1'b1;
         res = neg_ff[DIV_STEPS] ? Q_MIN : Q_MAX;
      end else if (neg_ff[DIV_STEPS]) begin
         if (quo_ff[DIV_STEPS] > Q_MIN) begin
            res_sat = 1'b1;
            res = Q_MIN;
         end else begin
            res = '0 - quo_ff[DIV_STEPS];
         end
      end else if (quo_ff[DIV_STEPS][Q_W-1]) begin
         res_sat = 1'b1;
         res = Q_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= res;
         sat_ff <= res_sat;
      end
   end

   assign quot = $signed(quot_ff);
   assign sat = sat_ff;

endmodule

// ===== src/ppt_out_buf.sv =====
module ppt_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ppt_pkg::rsp_word_type  in_word,
   output logic                   in_ready,
   output logic                   out_valid,
   output ppt_pkg::rsp_word_type  out_word,
   input  logic                   out_stall
);
   import ppt_pkg::*;

   logic         out_v_ff, out_v_in;
   logic         skid_v_ff, skid_v_in;
   rsp_word_type out_w_ff, out_w_in;
   rsp_word_type skid_w_ff, skid_w_in;
   logic         take_in, out_free;

   assign in_ready = !skid_v_ff;
   assign take_in = in_valid && !skid_v_ff;
   assign out_free = !out_v_ff || !out_stall;

   always_comb begin
      out_v_in = out_v_ff;
      out_w_in = out_w_ff;
      skid_v_in = skid_v_ff;
      skid_w_in = skid_w_ff;
      if (out_free) begin
         if (skid_v_ff) begin
            out_v_in = 1'b1;
            out_w_in = skid_w_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = take_in;
            out_w_in = in_word;
         end
      end else if (take_in) begin
         skid_v_in = 1'b1;
         skid_w_in = in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_w_ff <= out_w_in;
      skid_w_ff <= skid_w_in;
   end

   assign out_valid = out_v_ff;
   assign out_word = out_w_ff;

endmodule

// ===== src/perspective_point_transform_core.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_data (in_x, in_y)
// rsp      out        rsp_valid/rsp_stall   rsp_data (out_x, out_y, flags)
// csr      in         APB write/read        coefficients a..h
//
// One word is taken per cycle while req_stall is low.
// The pipeline holds the 32 restoring division steps, one pipeline stage each.
// Reset is synchronous and restores the identity transform.
// A stalled result is held while one more word drains into a skid register.
// req_stall rises only while that skid register is occupied.
module perspective_point_transform_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ppt_pkg::req_word_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ppt_pkg::rsp_word_type           rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ppt_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [ppt_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [ppt_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import ppt_pkg::*;

   coef_set_type coef_ff;
   coef_sel_type csr_sel;
   logic         csr_wr;
   logic         en;
   logic         buf_ready;

   logic         in_v_ff;
   req_word_type in_w_ff;

   lin_out_type  lin;
   logic signed [Q_W-1:0] quot_x, quot_y;
   logic         sat_x, sat_y;

   logic         side_v_ff [DIV_LAT];
   logic         side_z_ff [DIV_LAT];
   rsp_word_type fin_word;

   assign csr_pready = 1'b1;
   assign csr_sel = coef_sel_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{coef_a: COEF_ONE, coef_e: COEF_ONE, default: '0};
      end else if (csr_wr) begin
         case (csr_sel)
            COEF_A: coef_ff.coef_a <= csr_pwdata;
            COEF_B: coef_ff.coef_b <= csr_pwdata;
            COEF_C: coef_ff.coef_c <= csr_pwdata;
            COEF_D: coef_ff.coef_d <= csr_pwdata;
            COEF_E: coef_ff.coef_e <= csr_pwdata;
            COEF_F: coef_ff.coef_f <= csr_pwdata;
            COEF_G: coef_ff.coef_g <= csr_pwdata;
            COEF_H: coef_ff.coef_h <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         COEF_A: csr_prdata = coef_ff.coef_a;
         COEF_B: csr_prdata = coef_ff.coef_b;
         COEF_C: csr_prdata = coef_ff.coef_c;
         COEF_D: csr_prdata = coef_ff.coef_d;
         COEF_E: csr_prdata = coef_ff.coef_e;
         COEF_F: csr_prdata = coef_ff.coef_f;
         COEF_G: csr_prdata = coef_ff.coef_g;
         COEF_H: csr_prdata = coef_ff.coef_h;
         default: csr_prdata = '0;
      endcase
   end

   assign en = buf_ready;
   assign req_stall = !buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_w_ff <= req_data;
      end
   end

   ppt_linear u_linear (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_v_ff),
      .in_word  (in_w_ff),
      .coef     (coef_ff),
      .lin_out  (lin)
   );

   ppt_divider u_div_x (
      .clock   (clock),
      .en      (en),
      .num_mag (lin.num_x),
      .den_mag (lin.den),
      .neg     (lin.neg_x),
      .quot    (quot_x),
      .sat     (sat_x)
   );

   ppt_divider u_div_y (
      .clock   (clock),
      .en      (en),
      .num_mag (lin.num_y),
      .den_mag (lin.den),
      .neg     (lin.neg_y),
      .quot    (quot_y),
      .sat     (sat_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            side_v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         side_v_ff[0] <= lin.valid;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_v_ff[i] <= side_v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_z_ff[0] <= lin.zero;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_z_ff[i] <= side_z_ff[i-1];
         end
      end
   end

   always_comb begin
      fin_word.zero_denominator = side_z_ff[DIV_LAT-1];
      fin_word.out_x = side_z_ff[DIV_LAT-1] ? '0 : quot_x;
      fin_word.out_y = side_z_ff[DIV_LAT-1] ? '0 : quot_y;
      fin_word.saturated = !side_z_ff[DIV_LAT-1] && (sat_x || sat_y);
   end

   ppt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (side_v_ff[DIV_LAT-1]),
      .in_word   (fin_word),
      .in_ready  (buf_ready),
      .out_valid (rsp_valid),
      .out_word  (rsp_data),
      .out_stall (rsp_stall)
   );

`ifndef SYNTH
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denominator |->
         rsp_data.out_x == 0 && rsp_data.out_y == 0 && !rsp_data.saturated)
      else $error("zero denominator word carries nonzero fields");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.out_x == $signed(Q_MAX) || rsp_data.out_x == $signed(Q_MIN) ||
         rsp_data.out_y == $signed(Q_MAX) || rsp_data.out_y == $signed(Q_MIN))
      else $error("saturated word has no coordinate at a limit");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled while no result is pending");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ppt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int POINTS_PER_SETTING = 165;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   logic signed [Q_W-1:0] coef_q [8];
   req_word_type pending_points[$];
   rsp_word_type expected_points[$];
   logic req_taken = 1'b0;
   int sender_idle_pct = 8;
   int stall_pct = 76;
   int error_count = 0;
   int cycle_count = 0;

   perspective_point_transform_core i_dut (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Truncated Q16.16 quotient with saturation; bit 32 flags a clipped value.
   function automatic logic [32:0] q16_quotient(input logic signed [65:0] num,
                                                input logic [65:0] den_mag,
                                                input logic den_neg);
      logic num_neg;
      logic [65:0] num_mag;
      logic [81:0] quo;
      num_neg = num[65];
      num_mag = num_neg ? -num : num;
      quo = {num_mag, 16'b0} / {16'b0, den_mag};
      if (num_neg ^ den_neg) begin
         if (quo > 82'h80000000) return {1'b1, Q_MIN};
         return {1'b0, ~quo[31:0] + 32'd1};
      end
      if (quo > 82'h7FFFFFFF) return {1'b1, Q_MAX};
      return {1'b0, quo[31:0]};
   endfunction

   function automatic rsp_word_type project_point(input req_word_type pt);
      longint px, py;
      logic signed [65:0] den, nx, ny;
      logic [65:0] den_mag;
      logic [32:0] qx, qy;
      rsp_word_type r;
      px = longint'(pt.in_x);
      py = longint'(pt.in_y);
      den = longint'(coef_q[COEF_G]) * px + longint'(coef_q[COEF_H]) * py + (64'sd1 <<< 32);
      nx = longint'(coef_q[COEF_A]) * px + longint'(coef_q[COEF_B]) * py
           + longint'(coef_q[COEF_C]) * 65536;
      ny = longint'(coef_q[COEF_D]) * px + longint'(coef_q[COEF_E]) * py
           + longint'(coef_q[COEF_F]) * 65536;
      r = '0;
      if (den == 0) begin
         r.zero_denominator = 1'b1;
      end else begin
         den_mag = den[65] ? -den : den;
         qx = q16_quotient(nx, den_mag, den[65]);
         qy = q16_quotient(ny, den_mag, den[65]);
         r.out_x = qx[31:0];
         r.out_y = qy[31:0];
         r.saturated = qx[32] | qy[32];
      end
      return r;
   endfunction

   function automatic logic [Q_W-1:0] extreme_value();
      case ($urandom_range(6))
         0: return '0;
         1: return 32'd1;
         2: return '1;
         3: return Q_MAX;
         4: return Q_MIN;
         5: return COEF_ONE;
         default: return -COEF_ONE;
      endcase
   endfunction

   function automatic req_word_type random_point();
      req_word_type pt;
      longint g, h, span;
      span = 64'sd1 <<< 32;
      g = longint'(coef_q[COEF_G]);
      h = longint'(coef_q[COEF_H]);
      pt.in_x = $urandom;
      pt.in_y = $urandom;
      case ($urandom_range(9))
         5, 6, 7: begin
            pt.in_x = $urandom_range(134217727) - 67108864;
            pt.in_y = $urandom_range(134217727) - 67108864;
         end
         8: begin
            pt.in_x = extreme_value();
            pt.in_y = extreme_value();
         end
         9: begin
            // Aim for a denominator of exactly zero where the weights allow it.
            if (g != 0 && span % g == 0 && -span / g <= 64'sd2147483647) begin
               pt.in_x = 32'(-span / g);
               pt.in_y = '0;
            end else if (h != 0 && span % h == 0 && -span / h <= 64'sd2147483647) begin
               pt.in_x = '0;
               pt.in_y = 32'(-span / h);
            end
         end
         default: ;
      endcase
      return pt;
   endfunction

   task automatic queue_point(input logic [Q_W-1:0] x, input logic [Q_W-1:0] y);
      req_word_type pt;
      pt.in_x = x;
      pt.in_y = y;
      pending_points.push_back(pt);
   endtask

   task automatic csr_access(input logic is_write, input coef_sel_type sel,
                             input logic [Q_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= CSR_AW'({sel, 2'b00});
      csr_pwdata <= is_write ? value : '0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (is_write) begin
         coef_q[sel] = value;
      end else if (csr_prdata !== coef_q[sel]) begin
         $display("%0t: register %s read expected %h, got %h", $time, sel.name(),
                  coef_q[sel], csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic load_coefs(input logic [Q_W-1:0] vals [8]);
      for (int i = 0; i < 8; i++) csr_access(1'b1, coef_sel_type'(i), vals[i]);
      for (int i = 0; i < 8; i++) csr_access(1'b0, coef_sel_type'(i), '0);
   endtask

   task automatic wait_drained();
      while (pending_points.size() != 0 || req_valid || expected_points.size() != 0)
         @(negedge clock);
      repeat (DIV_LAT + 8) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data <= pending_points.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      rsp_word_type want;
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) expected_points.push_back(project_point(req_data));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("%0t: result word with none expected, got x=%h y=%h zero=%b sat=%b",
                     $time, rsp_data.out_x, rsp_data.out_y, rsp_data.zero_denominator,
                     rsp_data.saturated);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: expected x=%h y=%h zero=%b sat=%b, got x=%h y=%h zero=%b sat=%b",
                        $time, want.out_x, want.out_y, want.zero_denominator, want.saturated,
                        rsp_data.out_x, rsp_data.out_y, rsp_data.zero_denominator,
                        rsp_data.saturated);
               error_count++;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      logic [Q_W-1:0] vals [8];
      int k;
      coef_q = '{COEF_ONE, 0, 0, 0, COEF_ONE, 0, 0, 0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++) csr_access(1'b0, coef_sel_type'(i), '0);

      queue_point('0, '0);
      queue_point(Q_MAX, Q_MAX);
      queue_point(Q_MIN, Q_MIN);
      queue_point(Q_MAX, Q_MIN);
      queue_point(32'd1, '1);
      queue_point(COEF_ONE, -COEF_ONE);
      queue_point(32'h55555555, 32'hAAAAAAAA);
      queue_point(32'hAAAAAAAA, 32'h55555555);
      wait_drained();

      // With g at -1.0 the denominator vanishes at x = 1.0.
      vals = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, -COEF_ONE, 0};
      load_coefs(vals);
      queue_point(COEF_ONE, '0);
      queue_point(COEF_ONE, Q_MAX);
      queue_point('0, '0);
      queue_point(Q_MAX, Q_MAX);
      queue_point(Q_MIN, Q_MIN);
      queue_point(COEF_ONE << 1, '0);
      queue_point(COEF_ONE - 32'd1, '0);
      queue_point(COEF_ONE + 32'd1, '0);
      queue_point(32'd1, 32'd1);
      queue_point('1, '1);
      wait_drained();

      for (int s = 0; s < 10; s++) begin
         if (s == 3) begin
            sender_idle_pct = 76;
            stall_pct = 8;
         end
         if (s == 6) begin
            sender_idle_pct = 0;
            stall_pct = 0;
         end
         for (int i = 0; i < 8; i++) vals[i] = $urandom;
         case (s % 5)
            0, 4: begin
               vals[COEF_A] = $urandom_range(262143) - 131072;
               vals[COEF_B] = $urandom_range(131071) - 65536;
               vals[COEF_D] = $urandom_range(131071) - 65536;
               vals[COEF_E] = $urandom_range(262143) - 131072;
               vals[COEF_G] = $urandom_range(127) - 64;
               vals[COEF_H] = $urandom_range(127) - 64;
               if (s % 5 == 4) begin
                  vals[COEF_C] = '0;
                  vals[COEF_F] = '0;
               end
            end
            2: begin
               k = $urandom_range(30, 2);
               vals[COEF_G] = $urandom_range(1) ? (32'd1 << k) : -(32'd1 << k);
               k = $urandom_range(30, 2);
               vals[COEF_H] = $urandom_range(1) ? '0 : -(32'd1 << k);
            end
            3: begin
               for (int i = 0; i < 8; i++) vals[i] = (s < 5) ? Q_MAX : Q_MIN;
            end
            default: ;
         endcase
         load_coefs(vals);
         repeat (POINTS_PER_SETTING / 2) pending_points.push_back(random_point());
         wait_drained();
         repeat (POINTS_PER_SETTING - POINTS_PER_SETTING / 2)
            pending_points.push_back(random_point());
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
